>>> rtl/core/kms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;
  localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
  localparam int unsigned ROT_A = 24;
  localparam int unsigned ROT_B = 13;
  localparam int unsigned ROT_C = 15;
  localparam logic [0:0] REG_KMER = 1'b0;
  localparam logic [0:0] REG_HASHES = 1'b1;

  // one queued byte from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [5:0] k;
    logic [4:0] nh;
  } byte_cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/kms_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// two-entry queue between front and back
module kms_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire kms_pkg::byte_cmd_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output kms_pkg::byte_cmd_t     head
);
  kms_pkg::byte_cmd_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    !(full && empty)) else $error("queue count bad");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full) else $error("queue lost entry");
endmodule
`default_nettype wire

>>> rtl/core/kms_back.sv
`timescale 1ns / 1ps
`default_nettype none
// hash engine: window, per-index min and signature, result emission
module kms_back #(
  parameter int MAX_KMER   = 32,
  parameter int MAX_HASHES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire kms_pkg::byte_cmd_t cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_index,
  output logic [31:0]            out_sig,
  output logic                   out_last
);
  localparam int KW = $clog2(MAX_KMER + 1);
  localparam int PW = $clog2(MAX_KMER);
  localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int HC = $clog2(MAX_HASHES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LD    = 4'd2;
  localparam logic [3:0] S_W1    = 4'd3;
  localparam logic [3:0] S_W2    = 4'd4;
  localparam logic [3:0] S_W3    = 4'd5;
  localparam logic [3:0] S_TAIL  = 4'd6;
  localparam logic [3:0] S_F1    = 4'd7;
  localparam logic [3:0] S_F2    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  logic [3:0]  state;
  logic [7:0]  win [MAX_KMER];
  logic [KW-1:0] seen;
  logic [31:0] min_hash [MAX_HASHES];
  logic [31:0] sig_store [MAX_HASHES];
  logic [MAX_HASHES-1:0] vld;
  logic        last;
  logic [KW-1:0] len;
  logic [HC-1:0] nh;
  logic [HW-1:0] n;
  logic        pass;     // 0: seed n, 1: seed 3n
  logic [31:0] h;
  logic [31:0] w;
  logic [31:0] hv;
  logic [KW-1:0] pos;    // bytes consumed
  logic [KW-1:0] rest;

  logic [KW-1:0] k_eff;
  logic [KW-1:0] seen_next;
  logic [HC-1:0] nh_eff;
  logic [31:0] cur_min;
  logic [31:0] seed;

  function automatic logic [7:0] wb(input logic [KW-1:0] p, input logic [KW-1:0] l,
                                    input logic [7:0] a [MAX_KMER]);
    logic [KW:0] idx;
    idx = {1'b0, KW'(MAX_KMER)} - {1'b0, l} + {1'b0, p};
    return a[idx[PW-1:0]];
  endfunction

  always_comb begin
    k_eff = (cmd.k == 6'd0) ? KW'(1) :
            (32'(cmd.k) > 32'(MAX_KMER)) ? KW'(MAX_KMER) : KW'(cmd.k);
    nh_eff = (cmd.nh == 5'd0) ? HC'(1) :
             (32'(cmd.nh) > 32'(MAX_HASHES)) ? HC'(MAX_HASHES) : HC'(cmd.nh);
    seen_next = (seen < KW'(MAX_KMER)) ? seen + KW'(1) : seen;
    cur_min = vld[n] ? min_hash[n] : 32'hffffffff;
    seed = pass ? 32'(n) * 32'd3 : 32'(n);
  end

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign out_valid = (state == S_EMIT);
  assign out_index = 4'(n);
  assign out_sig   = vld[n] ? sig_store[n] : 32'd0;
  assign out_last  = (HC'(n) + HC'(1) == nh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen  <= '0;
      vld   <= '0;
      for (int i = 0; i < MAX_KMER; i++) win[i] <= 8'd0;
    end else begin
      case (state)
        S_IDLE: if (cmd_valid) begin
          for (int i = 0; i < MAX_KMER - 1; i++) win[i] <= win[i+1];
          win[MAX_KMER-1] <= cmd.data;
          seen <= seen_next;
          last <= cmd.last;
          nh   <= nh_eff;
          n    <= '0;
          pass <= 1'b0;
          if (seen_next >= k_eff) begin
            len <= k_eff; state <= S_START;
          end else if (cmd.last) begin
            len <= seen_next; state <= S_START;
          end else begin
            state <= S_IDLE;
          end
        end
        S_START: begin
          h <= seed ^ 32'(len);
          pos <= '0; rest <= len;
          state <= (len >= KW'(4)) ? S_LD : S_TAIL;
        end
        S_LD: begin
          w <= {wb(pos + KW'(3), len, win), wb(pos + KW'(2), len, win),
                wb(pos + KW'(1), len, win), wb(pos, len, win)};
          state <= S_W1;
        end
        S_W1: begin w <= w * kms_pkg::MIX_MUL; h <= h * kms_pkg::MIX_MUL; state <= S_W2; end
        S_W2: begin w <= (w ^ (w >> kms_pkg::ROT_A)) * kms_pkg::MIX_MUL; state <= S_W3; end
        S_W3: begin
          h <= h ^ w; pos <= pos + KW'(4); rest <= rest - KW'(4);
          state <= (rest - KW'(4) >= KW'(4)) ? S_LD : S_TAIL;
        end
        S_TAIL: begin
          if (rest != '0) begin
            h <= (h ^ (rest == KW'(3) ? {8'd0, wb(pos + KW'(2), len, win), 16'd0} : 32'd0)
                    ^ (rest >= KW'(2) ? {16'd0, wb(pos + KW'(1), len, win), 8'd0} : 32'd0)
                    ^ {24'd0, wb(pos, len, win)}) * kms_pkg::MIX_MUL;
          end
          state <= S_F1;
        end
        S_F1: begin h <= (h ^ (h >> kms_pkg::ROT_B)) * kms_pkg::MIX_MUL; state <= S_F2; end
        S_F2: begin hv <= h ^ (h >> kms_pkg::ROT_C); state <= S_DONE; end
        S_DONE: begin
          if (!pass) begin
            if (hv < cur_min) begin
              min_hash[n] <= hv; pass <= 1'b1; state <= S_START;
            end else if (HC'(n) + HC'(1) < nh) begin
              n <= n + HW'(1); state <= S_START;
            end else begin
              n <= '0; state <= last ? S_EMIT : S_IDLE;
            end
          end else begin
            sig_store[n] <= hv; vld[n] <= 1'b1; pass <= 1'b0;
            if (HC'(n) + HC'(1) < nh) begin
              n <= n + HW'(1); state <= S_START;
            end else begin
              n <= '0; state <= last ? S_EMIT : S_IDLE;
            end
          end
        end
        S_EMIT: if (out_ready) begin
          if (out_last) begin
            state <= S_CLR;
            vld <= '0; seen <= '0;
            for (int i = 0; i < MAX_KMER; i++) win[i] <= 8'd0;
          end else begin
            n <= n + HW'(1);
          end
        end
        S_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index)) else $error("emit dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_IDLE) else $error("pop while busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> vld == '0) else $error("not cleared");
endmodule
`default_nettype wire

>>> rtl/core/kmer_minhash_signature.sv
`timescale 1ns / 1ps
`default_nettype none
// K-mer MinHash signature. Bytes enter one word per handshake on s_axis
// (tdata = seq_byte, tuser = last_byte). A front part tags each byte with
// the current k and hash count and pushes it into a two-entry queue; the
// back part keeps the window and runs MurmurHash2 for each index n (seed n,
// and again with seed 3n on a new minimum). Each hash run steps through
// start, then load and mix steps for each 4-byte block, then tail,
// finalize and done; the back part takes no new byte from the queue until
// all hash runs for the current byte are done. Bytes before the first full
// k-mer, but for a last byte, are only shifted into the window.
// On the last byte, num_hashes words leave on m_axis, one per cycle when
// accepted, then state is cleared
// (tdata = {signature, hash_index}, tuser = last_signature).
// Config: cfg_index 0 = kmer_length, 1 = num_hashes; write only when idle.
module kmer_minhash_signature #(
  parameter int MAX_KMER   = 32,
  parameter int MAX_HASHES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // seq_byte
  input  wire logic        s_axis_tuser,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // hash_index[3:0], signature[35:4], zero pad
  output logic             m_axis_tuser,   // last_signature
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);
  logic [5:0] kmer_length;
  logic [4:0] num_hashes;
  kms_pkg::byte_cmd_t push_data;
  kms_pkg::byte_cmd_t head;
  logic full, empty, pop;
  logic [3:0]  idx;
  logic [31:0] sig;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= 6'd16;
      num_hashes  <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == kms_pkg::REG_KMER) kmer_length <= cfg_data;
      else num_hashes <= cfg_data[4:0];
    end
  end

  assign s_axis_tready = !full;
  assign push_data = '{data: s_axis_tdata, last: s_axis_tuser, k: kmer_length, nh: num_hashes};

  kms_queue u_queue (
    .clk(clk), .rst(rst), .push(s_axis_tvalid), .push_data(push_data), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  kms_back #(.MAX_KMER(MAX_KMER), .MAX_HASHES(MAX_HASHES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!empty), .cmd(head), .cmd_pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(idx),
    .out_sig(sig), .out_last(m_axis_tuser)
  );

  assign m_axis_tdata = {4'd0, sig, idx};
endmodule
`default_nettype wire
